/* sv/b64d_pkg.sv */
// b64d_pkg: shared types and the character classifier of the base64url decoder
// used by b64d_front, b64d_queue and b64d_back; depends on nothing
`default_nettype none

package b64d_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned SextetW = 6;

  typedef enum logic [1:0] {
    CharBlank,
    CharBad,
    CharData
  } char_kind_e;

  // one classified character as it travels from front to back
  typedef struct packed {
    char_kind_e           kind;
    logic [SextetW-1:0]   sextet;
    logic                 last;
  } char_item_t;

  // maps a character to its kind and, for alphabet characters, its 6-bit value
  function automatic char_item_t classify(input logic [CharW-1:0] c, input logic last);
    char_item_t      item;
    logic [CharW-1:0] diff;
    item.kind   = CharBad;
    item.sextet = '0;
    item.last   = last;
    diff        = '0;
    case (c) inside
      [8'd9:8'd13], 8'd32: begin
        item.kind = CharBlank;
      end
      [8'h41:8'h5A]: begin
        diff        = c - 8'h41;
        item.kind   = CharData;
        item.sextet = diff[SextetW-1:0];
      end
      [8'h61:8'h7A]: begin
        diff        = c - 8'h47;
        item.kind   = CharData;
        item.sextet = diff[SextetW-1:0];
      end
      [8'h30:8'h39]: begin
        diff        = c + 8'd4;
        item.kind   = CharData;
        item.sextet = diff[SextetW-1:0];
      end
      8'h2D: begin
        item.kind   = CharData;
        item.sextet = 6'd62;
      end
      8'h5F: begin
        item.kind   = CharData;
        item.sextet = 6'd63;
      end
      default: begin
        item.kind = CharBad;
      end
    endcase
    return item;
  endfunction

endpackage

`default_nettype wire

/* sv/base64url_decoder.sv */
// base64url_decoder: top level of the streaming unpadded base64url decoder
// depends on b64d_pkg, b64d_front, b64d_queue and b64d_back
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------------------
//   input   | in        | in_valid_i/in_stall_o   | text_char_i, text_end_i
//   output  | out       | out_valid_o/out_stall_i | out_byte_o, byte_present_o,
//           |           |                         | bad_text_o, result_end_o
//
// one character per cycle sustained while the output is not stalled; a character's
// result passes the front register, the queue and then the result register
// the front stalls only when its register is full and the two-entry queue is full
// the back pops the queue whenever the result register is empty or being drained
// reset is asynchronous, active low, and clears phase, pending bits, error and valids
`default_nettype none

module base64url_decoder (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] text_char_i,
  input  wire logic       text_end_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            byte_present_o,
  output logic            bad_text_o,
  output logic            result_end_o
);
  import b64d_pkg::*;

  // front to queue
  logic       push;
  char_item_t push_item;
  logic       q_full;

  // queue to back
  logic       pop;
  logic       q_empty;
  char_item_t head;

  // classify characters: blank, invalid, or alphabet with its sextet
  b64d_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .text_char_i (text_char_i),
    .text_end_i  (text_end_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_item_o (push_item)
  );

  // decouples classification from assembly so each side can stall alone
  b64d_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (head)
  );

  // four-phase byte assembly, sticky error and the result register
  b64d_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .byte_present_o (byte_present_o),
    .bad_text_o     (bad_text_o),
    .result_end_o   (result_end_o)
  );

endmodule

`default_nettype wire

/* sv/b64d_front.sv */
// b64d_front: input stage, takes characters and classifies them into a register
// depends on b64d_pkg
`default_nettype none

module b64d_front (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [b64d_pkg::CharW-1:0] text_char_i,
  input  wire logic                     text_end_i,
  input  wire logic                     q_full_i,
  output logic                          push_o,
  output b64d_pkg::char_item_t          push_item_o
);
  import b64d_pkg::*;

  logic       valid_q, valid_d;
  char_item_t item_q;
  logic       accept;

  assign in_stall_o  = valid_q && q_full_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign push_o      = valid_q && !q_full_i;
  assign push_item_o = item_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= classify(text_char_i, text_end_i);
    end
  end

endmodule

`default_nettype wire

/* sv/b64d_queue.sv */
// b64d_queue: two-entry queue of classified characters between front and back
// depends on b64d_pkg
`default_nettype none

module b64d_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire b64d_pkg::char_item_t push_item_i,
  output logic                      full_o,
  input  wire logic                 pop_i,
  output logic                      empty_o,
  output b64d_pkg::char_item_t      head_o
);
  import b64d_pkg::*;

  char_item_t  entry_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

/* sv/b64d_back.sv */
// b64d_back: sextet assembly state and the registered result stage
// depends on b64d_pkg
`default_nettype none

module b64d_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 q_empty_i,
  input  wire b64d_pkg::char_item_t head_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [7:0]                out_byte_o,
  output logic                      byte_present_o,
  output logic                      bad_text_o,
  output logic                      result_end_o
);
  import b64d_pkg::*;

  logic [1:0] phase_q, phase_d;
  logic [7:0] pend_q, pend_d;
  logic       err_q, err_d;
  logic       out_valid_q;
  logic [7:0] byte_q;
  logic       have_q, bad_q, end_q;

  logic       have;
  logic [7:0] byte_val;
  logic [5:0] s;

  assign pop_o          = !q_empty_i && (!out_valid_q || !out_stall_i);
  assign s              = head_i.sextet;
  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = byte_q;
  assign byte_present_o = have_q;
  assign bad_text_o     = bad_q;
  assign result_end_o   = end_q;

  always_comb begin
    phase_d  = phase_q;
    pend_d   = pend_q;
    err_d    = err_q;
    have     = 1'b0;
    byte_val = 8'd0;
    case (head_i.kind)
      CharBad: begin
        err_d = 1'b1;
      end
      CharData: begin
        have    = (phase_q != 2'd0);
        phase_d = phase_q + 2'd1;
        case (phase_q)
          2'd0: begin
            pend_d = {s, 2'b00};
          end
          2'd1: begin
            byte_val = pend_q | {6'd0, s[5:4]};
            pend_d   = {s[3:0], 4'd0};
          end
          2'd2: begin
            byte_val = pend_q | {4'd0, s[5:2]};
            pend_d   = {s[1:0], 6'd0};
          end
          default: begin
            byte_val = pend_q | {2'd0, s};
            pend_d   = 8'd0;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 2'd0;
      pend_q      <= 8'd0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
      byte_q      <= 8'd0;
      have_q      <= 1'b0;
      bad_q       <= 1'b0;
      end_q       <= 1'b0;
    end else begin
      // a new result replaces the one leaving, otherwise a drained register empties
      if (pop_o && (have || head_i.last)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o) begin
        // the last character closes the text and drops leftover bits
        if (head_i.last) begin
          phase_q <= 2'd0;
          pend_q  <= 8'd0;
          err_q   <= 1'b0;
        end else begin
          phase_q <= phase_d;
          pend_q  <= pend_d;
          err_q   <= err_d;
        end
        if (have || head_i.last) begin
          byte_q      <= byte_val;
          have_q      <= have;
          bad_q       <= err_d;
          end_q       <= head_i.last;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* verif/base64url_checker.sv */
// base64url_checker: watches both channels of the base64url decoder, predicts each
// decoded result and compares it; uses char_kind_e from b64d_pkg
module base64url_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] text_char_i,
  input  logic       text_end_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] out_byte_i,
  input  logic       byte_present_i,
  input  logic       bad_text_i,
  input  logic       result_end_i,
  output int         fail_count_o,
  output int         pending_results_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import b64d_pkg::*;

  typedef enum logic [1:0] {
    GrpFirst,
    GrpSecond,
    GrpThird,
    GrpFourth
  } group_phase_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_present;
    logic       bad_text;
    logic       result_end;
  } decoded_t;

  group_phase_e grp_phase;
  logic [7:0]   held_bits;
  logic         bad_seen;
  decoded_t     decoded_due[$];
  int           mismatch_count = 0;
  int           results_seen   = 0;

  assign fail_count_o = mismatch_count;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  function automatic char_kind_e kind_of(input logic [7:0] c);
    if ((c >= 8'd9 && c <= 8'd13) || c == 8'd32) return CharBlank;
    if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9") ||
        c == "-" || c == "_") return CharData;
    return CharBad;
  endfunction

  function automatic logic [5:0] sextet_value(input logic [7:0] c);
    logic [7:0] v;
    if (c >= "A" && c <= "Z") v = c - "A";
    else if (c >= "a" && c <= "z") v = c - "a" + 8'd26;
    else if (c >= "0" && c <= "9") v = c - "0" + 8'd52;
    else if (c == "-") v = 8'd62;
    else v = 8'd63;
    return v[5:0];
  endfunction

  function automatic void clear_text();
    grp_phase = GrpFirst;
    held_bits = '0;
    bad_seen  = 1'b0;
  endfunction

  // advances the decoder state by one character; returns 1 when a result is due
  function automatic logic decode_step(input logic [7:0] c, input logic e,
                                       output decoded_t res);
    char_kind_e kind;
    logic [5:0] s;
    logic       have;
    logic [7:0] b;
    kind = kind_of(c);
    have = 1'b0;
    b    = '0;
    if (kind == CharBad) begin
      bad_seen = 1'b1;
    end else if (kind == CharData) begin
      s = sextet_value(c);
      case (grp_phase)
        GrpFirst: begin
          held_bits = {s, 2'b00};
          grp_phase = GrpSecond;
        end
        GrpSecond: begin
          b         = held_bits | {6'b0, s[5:4]};
          held_bits = {s[3:0], 4'b0};
          have      = 1'b1;
          grp_phase = GrpThird;
        end
        GrpThird: begin
          b         = held_bits | {4'b0, s[5:2]};
          held_bits = {s[1:0], 6'b0};
          have      = 1'b1;
          grp_phase = GrpFourth;
        end
        default: begin
          b         = held_bits | {2'b0, s};
          held_bits = '0;
          have      = 1'b1;
          grp_phase = GrpFirst;
        end
      endcase
    end
    res.out_byte     = have ? b : 8'h00;
    res.byte_present = have;
    res.bad_text     = bad_seen;
    res.result_end   = e;
    // partial bits left at the end of a text are simply dropped
    if (e) clear_text();
    return have || e;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    decoded_t due;
    decoded_t fresh;
    if (!rst_ni) begin
      clear_text();
      decoded_due.delete();
      pending_results_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        results_seen++;
        if (decoded_due.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing due", results_seen));
        end else begin
          due = decoded_due.pop_front();
          if (out_byte_i !== due.out_byte)
            report_mismatch($sformatf("result %0d out_byte %h, want %h",
                                      results_seen, out_byte_i, due.out_byte));
          if (byte_present_i !== due.byte_present)
            report_mismatch($sformatf("result %0d byte_present %b, want %b",
                                      results_seen, byte_present_i, due.byte_present));
          if (bad_text_i !== due.bad_text)
            report_mismatch($sformatf("result %0d bad_text %b, want %b",
                                      results_seen, bad_text_i, due.bad_text));
          if (result_end_i !== due.result_end)
            report_mismatch($sformatf("result %0d result_end %b, want %b",
                                      results_seen, result_end_i, due.result_end));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (decode_step(text_char_i, text_end_i, fresh)) decoded_due.push_back(fresh);
      end
      pending_results_o <= decoded_due.size();
    end
  end

endmodule

/* verif/tb_base64url_decoder.sv */
// tb_base64url_decoder: stimulus, flow control and verdict for base64url_decoder
// needs the decoder RTL with b64d_pkg and base64url_checker, which does all checking
module tb_base64url_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  // roughly 1850 characters, then drain
  localparam int ItemTarget  = 1850;
  // worst case is far below this: every transfer waiting out a long receiver hold
  localparam int CycleLimit  = 400000;
  // a character passes the front register and the queue to reach the output register
  localparam int DrainCycles = 16;

  localparam string Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] text_char_i = 8'h00;
  logic       text_end_i  = 1'b0;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       byte_present_o;
  logic       bad_text_o;
  logic       result_end_o;

  int fail_count;
  int pending_results;
  int cycle_count = 0;
  int fed_items   = 0;
  // sender burst bookkeeping; no gaps while bursty is low
  int burst_left  = 0;
  bit bursty      = 1'b0;

  base64url_decoder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .text_char_i   (text_char_i),
    .text_end_i    (text_end_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .byte_present_o(byte_present_o),
    .bad_text_o    (bad_text_o),
    .result_end_o  (result_end_o)
  );

  // the checker sees exactly what the block sees on both channels
  base64url_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .text_char_i      (text_char_i),
    .text_end_i       (text_end_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_i       (out_byte_o),
    .byte_present_i   (byte_present_o),
    .bad_text_i       (bad_text_o),
    .result_end_i     (result_end_o),
    .fail_count_o     (fail_count),
    .pending_results_o(pending_results)
  );

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("base64url_decoder verification failed");
      $finish;
    end
  end

  // a character outside the alphabet and outside the whitespace set
  function automatic logic [7:0] bad_char();
    string odd;
    odd = "=+/.@[#{~!";
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(128, 255));
      1:       return 8'($urandom_range(0, 8));
      2:       return odd[$urandom_range(0, 9)];
      default: return 8'($urandom_range(14, 31));
    endcase
  endfunction

  function automatic logic [7:0] blank_char();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? 8'd32 : 8'(9 + k);
  endfunction

  // mostly alphabet, some whitespace, invalid characters only in dirty texts
  function automatic logic [7:0] text_char(input bit dirty);
    int r;
    r = $urandom_range(0, 99);
    if (dirty && r < 8) return bad_char();
    if (r < 20) return blank_char();
    return Alphabet[$urandom_range(0, 63)];
  endfunction

  // offers one character and holds it until the transfer happens
  task automatic send_char(input logic [7:0] c, input logic e);
    int gap;
    if (bursty) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 48);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;
    end
    in_valid_i  <= 1'b1;
    text_char_i <= c;
    text_end_i  <= e;
    // values read right after the edge are the ones the flops sampled
    do @(posedge clk_i); while (in_stall_o);
    fed_items++;
  endtask

  // receiver: opens with a long hold so the directed characters back up into the
  // block, then alternates free-flowing, light, heavy and long-hold stretches
  initial begin : receiver
    int span;
    int pct;
    wait (rst_ni === 1'b1);
    repeat (64) begin
      out_stall_i <= 1'b1;
      @(posedge clk_i);
    end
    forever begin
      span = $urandom_range(10, 120);
      case ($urandom_range(0, 9))
        0: begin
          pct  = 100;
          span = $urandom_range(40, 90);
        end
        1, 2, 3: pct = 0;
        4, 5, 6: pct = 30;
        default: pct = 75;
      endcase
      repeat (span) begin
        out_stall_i <= ($urandom_range(0, 99) < pct);
        @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    int  len;
    bit  dirty;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, back to back while the receiver holds off
    // alphabet ends with a space inside a group, bytes on all three completing phases
    send_char("A", 1'b0);
    send_char("_", 1'b0);
    send_char("a", 1'b0);
    send_char(8'd32, 1'b0);
    send_char("z", 1'b0);
    // digits and dash, tab and carriage return, a padding sign as invalid,
    // then a byte that completes on the last character
    send_char("0", 1'b0);
    send_char(8'd9, 1'b0);
    send_char("9", 1'b0);
    send_char(8'd13, 1'b0);
    send_char("-", 1'b0);
    send_char("=", 1'b0);
    send_char("Z", 1'b1);
    // one lone sextet: its bits are dropped at the end
    send_char("Q", 1'b1);
    // invalid character alone as the last one, lowest code
    send_char(8'h00, 1'b1);
    // whitespace alone as the last one
    send_char(8'd32, 1'b1);
    // text ending on whitespace in the fourth phase
    send_char("B", 1'b0);
    send_char("C", 1'b0);
    send_char("D", 1'b0);
    send_char(8'd10, 1'b1);
    // errors first, highest code and the codes just outside whitespace,
    // then decoding goes on with the error flag up
    send_char(8'hFF, 1'b0);
    send_char(8'd8, 1'b0);
    send_char(8'd14, 1'b0);
    send_char("e", 1'b0);
    send_char("f", 1'b1);

    // random part: sender now idles in bursts
    bursty = 1'b1;
    while (fed_items < ItemTarget) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise: any code, occasionally marked last
        repeat ($urandom_range(1, 8))
          send_char(8'($urandom_range(0, 255)), ($urandom_range(0, 15) == 0));
      end else begin
        // one text with random content, mostly short, now and then long
        dirty = ($urandom_range(0, 9) < 3);
        len   = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10);
        repeat (len) send_char(text_char(dirty), 1'b0);
        send_char(text_char(dirty), 1'b1);
      end
    end
    in_valid_i <= 1'b0;

    // let the count catch up with the last transfer, then drain
    repeat (2) @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("base64url_decoder verification clean");
    end else begin
      $display("base64url_decoder verification failed");
    end
    $finish;
  end

endmodule
